// ===== rtl/core/display_list_state_decoder_top_macros.svh =====
// Assertion shorthands shared by the checker files.
// All of them sample on clk and are off while rst is high.
`ifndef DISPLAY_LIST_STATE_DECODER_TOP_MACROS_SVH
`define DISPLAY_LIST_STATE_DECODER_TOP_MACROS_SVH

// Same-cycle implication.
`define DLSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DLSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/dlsd_pkg.sv =====
`timescale 1ns / 1ps
package dlsd_pkg;

  localparam int SEGMENTS  = 16;
  localparam int SEG_IDX_W = $clog2(SEGMENTS);

  // Command opcodes (top byte of word 0)
  localparam logic [7:0] OP_NOOP        = 8'h00;
  localparam logic [7:0] OP_MTX         = 8'h01;
  localparam logic [7:0] OP_MOVEMEM     = 8'h03;
  localparam logic [7:0] OP_VTX         = 8'h04;
  localparam logic [7:0] OP_DL          = 8'h06;
  localparam logic [7:0] OP_TRI2        = 8'hB1;
  localparam logic [7:0] OP_RDPHALF_CNT = 8'hB2;
  localparam logic [7:0] OP_RDPHALF_2   = 8'hB3;
  localparam logic [7:0] OP_RDPHALF_1   = 8'hB4;
  localparam logic [7:0] OP_LINE3D      = 8'hB5;
  localparam logic [7:0] OP_CLRGEOM     = 8'hB6;
  localparam logic [7:0] OP_SETGEOM     = 8'hB7;
  localparam logic [7:0] OP_ENDDL       = 8'hB8;
  localparam logic [7:0] OP_OTHERMODE_L = 8'hB9;
  localparam logic [7:0] OP_OTHERMODE_H = 8'hBA;
  localparam logic [7:0] OP_TEXTURE     = 8'hBB;
  localparam logic [7:0] OP_MOVEWORD    = 8'hBC;
  localparam logic [7:0] OP_POPMTX      = 8'hBD;
  localparam logic [7:0] OP_CULLDL      = 8'hBE;
  localparam logic [7:0] OP_TRI1        = 8'hBF;
  localparam logic [7:0] OP_RDP_NOOP    = 8'hC0;
  localparam logic [7:0] OP_RDP_FIRST   = 8'hC1;
  localparam logic [7:0] OP_IMAGE_FIRST = 8'hFD;

  // Moveword indices
  localparam logic [7:0] MW_LIGHTS   = 8'h02;
  localparam logic [7:0] MW_SEGMENT  = 8'h06;
  localparam logic [7:0] MW_PERSPNRM = 8'h0E;

  localparam logic [15:0] PERSP_RESET = 16'hFFFF;

  typedef enum logic [3:0] {
    KIND_ABSORBED = 4'd0,
    KIND_GEOMMODE = 4'd1,
    KIND_OTHER_H  = 4'd2,
    KIND_OTHER_L  = 4'd3,
    KIND_TEXTURE  = 4'd4,
    KIND_RDP      = 4'd5,
    KIND_END      = 4'd6,
    KIND_FETCH    = 4'd7,
    KIND_FORWARD  = 4'd8,
    KIND_UNKNOWN  = 4'd9
  } kind_t;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [23:0] low;
    logic [31:0] word1;
  } cmd_t;

  typedef struct packed {
    logic [31:0] geometry_mode;
    logic [31:0] othermode_high;
    logic [31:0] othermode_low;
    logic [2:0]  tex_level;
    logic [2:0]  tex_tile;
    logic        tex_on;
    logic [15:0] scale_s;
    logic [15:0] scale_t;
    logic [15:0] persp_norm;
    logic [6:0]  lights;
  } mode_state_t;

  // all zero but the perspective normalizer
  localparam mode_state_t STATE_RESET = '{32'd0, 32'd0, 32'd0, 3'd0, 3'd0, 1'b0,
                                          16'd0, 16'd0, PERSP_RESET, 7'd0};

  typedef struct packed {
    logic                 we;
    logic [SEG_IDX_W-1:0] idx;
    logic [31:0]          data;
  } seg_write_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [2:0]  tex_level;
    logic [2:0]  tex_tile;
    logic        tex_on;
    logic [15:0] scale_s;
    logic [15:0] scale_t;
    logic [6:0]  light_count;
    logic [15:0] persp_value;
    logic        end_list;
  } result_t;

endpackage

// ===== rtl/core/dlsd_decode.sv =====
`timescale 1ns / 1ps
module dlsd_decode (
  input  dlsd_pkg::cmd_t        cmd,
  input  dlsd_pkg::mode_state_t state,
  input  logic [31:0]           seg_base,
  output dlsd_pkg::mode_state_t state_next,
  output dlsd_pkg::seg_write_t  seg_wr,
  output dlsd_pkg::result_t     result
);

  logic [31:0] mode_mask;
  logic [31:0] translated;
  logic [31:0] len_ones;
  logic [4:0]  len5;
  logic [6:0]  light_raw;

  // Othermode field mask: length = byte0 + 1, shift = byte1
  always_comb begin
    len5     = cmd.low[4:0] + 5'd1;
    len_ones = ~(32'hFFFF_FFFF << len5);
    if (cmd.low[7:0] >= 8'd31) begin
      mode_mask = 32'hFFFF_FFFF;
    end else if (cmd.low[15:8] >= 8'd32) begin
      mode_mask = '0;
    end else begin
      mode_mask = len_ones << cmd.low[12:8];
    end
  end

  assign translated = seg_base + {8'd0, cmd.word1[23:0]};
  assign light_raw  = cmd.word1[11:5];

  always_comb begin
    dlsd_pkg::kind_t kind;
    logic [31:0]     ow1;
    logic            end_flag;

    kind       = dlsd_pkg::KIND_UNKNOWN;
    ow1        = '0;
    end_flag   = 1'b0;
    state_next = state;
    seg_wr     = '0;

    unique case (cmd.opcode)
      dlsd_pkg::OP_NOOP, dlsd_pkg::OP_MOVEMEM, dlsd_pkg::OP_RDPHALF_CNT,
      dlsd_pkg::OP_RDPHALF_2, dlsd_pkg::OP_RDPHALF_1, dlsd_pkg::OP_LINE3D,
      dlsd_pkg::OP_RDP_NOOP: begin
        kind = dlsd_pkg::KIND_ABSORBED;
      end
      dlsd_pkg::OP_MTX, dlsd_pkg::OP_VTX: begin
        kind = dlsd_pkg::KIND_FETCH;
        ow1  = translated;
      end
      dlsd_pkg::OP_DL: begin
        kind     = dlsd_pkg::KIND_FETCH;
        ow1      = translated;
        end_flag = (cmd.low[23:16] != 8'd0);
      end
      dlsd_pkg::OP_TRI2, dlsd_pkg::OP_TRI1, dlsd_pkg::OP_POPMTX,
      dlsd_pkg::OP_CULLDL: begin
        kind = dlsd_pkg::KIND_FORWARD;
        ow1  = cmd.word1;
      end
      dlsd_pkg::OP_ENDDL: begin
        kind     = dlsd_pkg::KIND_END;
        end_flag = 1'b1;
      end
      dlsd_pkg::OP_SETGEOM: begin
        state_next.geometry_mode = state.geometry_mode | cmd.word1;
        kind = dlsd_pkg::KIND_GEOMMODE;
        ow1  = state_next.geometry_mode;
      end
      dlsd_pkg::OP_CLRGEOM: begin
        state_next.geometry_mode = state.geometry_mode & ~cmd.word1;
        kind = dlsd_pkg::KIND_GEOMMODE;
        ow1  = state_next.geometry_mode;
      end
      dlsd_pkg::OP_OTHERMODE_H: begin
        state_next.othermode_high = (state.othermode_high & ~mode_mask)
                                  | (cmd.word1 & mode_mask);
        kind = dlsd_pkg::KIND_OTHER_H;
        ow1  = state_next.othermode_high;
      end
      dlsd_pkg::OP_OTHERMODE_L: begin
        state_next.othermode_low = (state.othermode_low & ~mode_mask)
                                 | (cmd.word1 & mode_mask);
        kind = dlsd_pkg::KIND_OTHER_L;
        ow1  = state_next.othermode_low;
      end
      dlsd_pkg::OP_TEXTURE: begin
        state_next.tex_level = cmd.low[13:11];
        state_next.tex_tile  = cmd.low[10:8];
        state_next.tex_on    = (cmd.low[7:0] != 8'd0);
        state_next.scale_s   = cmd.word1[31:16];
        state_next.scale_t   = cmd.word1[15:0];
        kind = dlsd_pkg::KIND_TEXTURE;
      end
      dlsd_pkg::OP_MOVEWORD: begin
        kind = dlsd_pkg::KIND_ABSORBED;
        priority if (cmd.low[7:0] == dlsd_pkg::MW_SEGMENT) begin
          // offset / 4 must land inside the table
          seg_wr.we   = (cmd.low[23:14] == 10'd0);
          seg_wr.idx  = cmd.low[13:10];
          seg_wr.data = cmd.word1;
        end else if (cmd.low[7:0] == dlsd_pkg::MW_LIGHTS) begin
          state_next.lights = (light_raw != 7'd0) ? light_raw - 7'd1 : 7'd0;
        end else if (cmd.low[7:0] == dlsd_pkg::MW_PERSPNRM) begin
          state_next.persp_norm = cmd.word1[15:0];
        end else begin
          state_next = state;
        end
      end
      default: begin
        if (cmd.opcode >= dlsd_pkg::OP_RDP_FIRST) begin
          kind = dlsd_pkg::KIND_RDP;
          ow1  = (cmd.opcode >= dlsd_pkg::OP_IMAGE_FIRST) ? translated : cmd.word1;
        end else begin
          kind = dlsd_pkg::KIND_UNKNOWN;
        end
      end
    endcase

    result.kind        = kind;
    result.word0       = {cmd.opcode, cmd.low};
    result.word1       = ow1;
    result.tex_level   = state_next.tex_level;
    result.tex_tile    = state_next.tex_tile;
    result.tex_on      = state_next.tex_on;
    result.scale_s     = state_next.scale_s;
    result.scale_t     = state_next.scale_t;
    result.light_count = state_next.lights;
    result.persp_value = state_next.persp_norm;
    result.end_list    = end_flag;
  end

endmodule

// ===== rtl/core/dlsd_state.sv =====
`timescale 1ns / 1ps
module dlsd_state (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             update,
  input  dlsd_pkg::mode_state_t            state_next,
  input  dlsd_pkg::seg_write_t             seg_wr,
  input  logic [dlsd_pkg::SEG_IDX_W-1:0]   seg_idx,
  output dlsd_pkg::mode_state_t            state,
  output logic [31:0]                      seg_base
);

  logic [31:0] segment_table [dlsd_pkg::SEGMENTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dlsd_pkg::STATE_RESET;
    end else if (update) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dlsd_pkg::SEGMENTS; i++) begin
        segment_table[i] <= '0;
      end
    end else if (update && seg_wr.we) begin
      segment_table[seg_wr.idx] <= seg_wr.data;
    end
  end

  assign seg_base = segment_table[seg_idx];

endmodule

// ===== rtl/core/display_list_state_decoder_top.sv =====
`timescale 1ns / 1ps
// Display-list command decoder. Each 64-bit command word enters on the s_ side,
// is held in an input register, and is decoded against the current
// render state (segment base table, geometry mode, othermode high/low, texture
// settings, perspective normalizer, light count); the state update and the
// result word are both taken at the same clock edge. Exactly one result word
// leaves on the m_ side per command, in order. Throughput is one command per
// cycle while m_tready is high; m_tvalid rises at the edge on which a word moves
// from the input register to the result register, and the result can be taken
// from then on. The decode path between the two registers is combinational.
// s_tready follows m_tready combinationally when both registers are
// full, so a stalled consumer stops input after at most two buffered words.
// m_tuser carries the result kind, m_tlast flags end of the current list
// (end-of-list command, or a branching display-list call). Segment translation
// uses bits 27:24 of word 1 as the segment and adds bits 23:0 to its base.
module display_list_state_decoder_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // opcode[7:0], cmd_low[31:8], cmd_word1[63:32]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // out_word0[31:0], out_word1[63:32],
                                  // tex_level[66:64], tex_tile[69:67],
                                  // tex_on[70], scale_s[86:71], scale_t[102:87],
                                  // light_count[109:103], persp_value[125:110],
                                  // zero pad[127:126]
  output logic [3:0]   m_tuser,   // kind[3:0]
  output logic         m_tlast    // end_list
);

  // input register
  logic                  in_valid;
  dlsd_pkg::cmd_t        in_cmd;

  // decode/state wiring
  dlsd_pkg::mode_state_t state;
  dlsd_pkg::mode_state_t state_next;
  dlsd_pkg::seg_write_t  seg_wr;
  dlsd_pkg::result_t     result;
  dlsd_pkg::result_t     out_res;
  logic [31:0]           seg_base;
  logic                  advance;

  // A word moves to the result register when the latter is free or draining.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd.opcode <= s_tdata[7:0];
      in_cmd.low    <= s_tdata[31:8];
      in_cmd.word1  <= s_tdata[63:32];
    end
  end

  dlsd_state u_state (
    .clk        (clk),
    .rst        (rst),
    .update     (advance),
    .state_next (state_next),
    .seg_wr     (seg_wr),
    .seg_idx    (in_cmd.word1[27:24]),
    .state      (state),
    .seg_base   (seg_base)
  );

  dlsd_decode u_decode (
    .cmd        (in_cmd),
    .state      (state),
    .seg_base   (seg_base),
    .state_next (state_next),
    .seg_wr     (seg_wr),
    .result     (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= result;
    end
  end

  assign m_tdata = {2'b00, out_res.persp_value, out_res.light_count, out_res.scale_t,
                    out_res.scale_s, out_res.tex_on, out_res.tex_tile,
                    out_res.tex_level, out_res.word1, out_res.word0};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.end_list;

endmodule

// ===== rtl/core/dlsd_checker.sv =====
`timescale 1ns / 1ps
`include "display_list_state_decoder_top_macros.svh"
module dlsd_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata,
  input logic [3:0]   m_tuser,
  input logic         m_tlast
);

  logic [132:0] out_word;
  logic         no_word1_kind;
  logic         list_end_kind;
  logic         end_kind;

  assign out_word      = {m_tuser, m_tlast, m_tdata};
  assign no_word1_kind = (m_tuser == dlsd_pkg::KIND_ABSORBED) ||
                         (m_tuser == dlsd_pkg::KIND_TEXTURE) ||
                         (m_tuser == dlsd_pkg::KIND_END) ||
                         (m_tuser == dlsd_pkg::KIND_UNKNOWN);
  assign list_end_kind = (m_tuser == dlsd_pkg::KIND_END) ||
                         (m_tuser == dlsd_pkg::KIND_FETCH);
  assign end_kind      = (m_tuser == dlsd_pkg::KIND_END);

  // a stalled result word must hold
  `DLSD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(out_word), "stalled word changed")

  // with the output side empty the input side is never blocked
  `DLSD_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready, "input blocked with empty output")

  // end-of-list only on end or fetch kinds, and always on end
  `DLSD_ASSERT_NOW(a_tlast_kind, m_tvalid && m_tlast, list_end_kind, "tlast on wrong kind")
  `DLSD_ASSERT_NOW(a_end_tlast, m_tvalid && end_kind, m_tlast, "end kind without tlast")

  // kinds without a second word carry zero there
  `DLSD_ASSERT_NOW(a_word1_zero, m_tvalid && no_word1_kind, m_tdata[63:32] == 32'd0, "nonzero word1")

endmodule

bind display_list_state_decoder_top dlsd_checker u_dlsd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ===== tb/display_list_state_decoder_top_tb.sv =====
`timescale 1ns / 1ps
module display_list_state_decoder_top_tb;

  // Codes the package does not name: a moveword index the block ignores,
  // two opcodes below the RDP range it does not decode, the last image opcode.
  localparam logic [7:0] MW_UNUSED      = 8'h03;
  localparam logic [7:0] OP_UNDEF_LOW   = 8'h02;
  localparam logic [7:0] OP_UNDEF_HIGH  = 8'hB0;
  localparam logic [7:0] OP_IMAGE_LAST  = 8'hFF;

  localparam int RANDOM_CMDS = 800;
  localparam int MAX_WAIT    = 12;    // longest gap / stall per word
  localparam int STALL_LIMIT = 4000;  // cycles with no word moving on either side
  localparam int TAIL_CYCLES = 8;     // settle time after the last result

  typedef struct packed {
    logic           drain;  // hold this command until every pending result is out
    dlsd_pkg::cmd_t cmd;
  } pending_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [63:0]  s_tdata;   // opcode[7:0], cmd_low[31:8], cmd_word1[63:32]
  logic         m_tvalid;
  logic         m_tready;
  logic [127:0] m_tdata;   // out_word0, out_word1, tex_level, tex_tile, tex_on,
                           // scale_s, scale_t, light_count, persp_value, pad
  logic [3:0]   m_tuser;   // kind
  logic         m_tlast;   // end_list

  display_list_state_decoder_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Shadow of the render state, advanced once per accepted command word.
  logic [31:0]           seg_base [dlsd_pkg::SEGMENTS];
  dlsd_pkg::mode_state_t render;

  pending_t              cmd_q [$];
  dlsd_pkg::result_t     expected_q [$];
  logic [7:0]            known_ops [$];
  logic [7:0]            simple_ops [$];

  int                    mismatches;
  int                    idle_cycles;
  int                    send_gap;
  int                    recv_stall;
  bit                    send_burst;
  bit                    recv_burst;
  pending_t              next_item;
  dlsd_pkg::cmd_t        cur_cmd;
  dlsd_pkg::result_t     want;

  function automatic logic [31:0] seg_addr(logic [31:0] addr);
    // Bits 31:28 play no part; base plus 24-bit offset wraps at 2^32.
    return seg_base[addr[27:24]] + {8'h00, addr[23:0]};
  endfunction

  function automatic logic [31:0] field_mask(logic [23:0] low);
    logic [8:0]  len;
    logic [7:0]  shift;
    logic [63:0] wide;
    len   = {1'b0, low[7:0]} + 9'd1;
    shift = low[15:8];
    if (len >= 9'd32) return '1;
    if (shift >= 8'd32) return '0;
    wide = ((64'd1 << len) - 64'd1) << shift;
    return wide[31:0];
  endfunction

  // Applies one command to the shadow state and returns the word it yields.
  function automatic dlsd_pkg::result_t decode_command(dlsd_pkg::cmd_t c);
    dlsd_pkg::result_t r;
    logic [31:0]       m;
    logic [6:0]        n;
    r       = '0;
    r.kind  = dlsd_pkg::KIND_ABSORBED;
    r.word0 = {c.opcode, c.low};
    case (c.opcode)
      dlsd_pkg::OP_NOOP, dlsd_pkg::OP_MOVEMEM, dlsd_pkg::OP_RDPHALF_CNT,
      dlsd_pkg::OP_RDPHALF_2, dlsd_pkg::OP_RDPHALF_1, dlsd_pkg::OP_LINE3D,
      dlsd_pkg::OP_RDP_NOOP: begin
        r.kind = dlsd_pkg::KIND_ABSORBED;
      end
      dlsd_pkg::OP_MTX, dlsd_pkg::OP_VTX: begin
        r.kind  = dlsd_pkg::KIND_FETCH;
        r.word1 = seg_addr(c.word1);
      end
      dlsd_pkg::OP_DL: begin
        r.kind     = dlsd_pkg::KIND_FETCH;
        r.word1    = seg_addr(c.word1);
        r.end_list = (c.low[23:16] != 8'h00);  // branch, not call
      end
      dlsd_pkg::OP_TRI2, dlsd_pkg::OP_TRI1, dlsd_pkg::OP_POPMTX,
      dlsd_pkg::OP_CULLDL: begin
        r.kind  = dlsd_pkg::KIND_FORWARD;
        r.word1 = c.word1;
      end
      dlsd_pkg::OP_ENDDL: begin
        r.kind     = dlsd_pkg::KIND_END;
        r.end_list = 1'b1;
      end
      dlsd_pkg::OP_SETGEOM: begin
        render.geometry_mode = render.geometry_mode | c.word1;
        r.kind  = dlsd_pkg::KIND_GEOMMODE;
        r.word1 = render.geometry_mode;
      end
      dlsd_pkg::OP_CLRGEOM: begin
        render.geometry_mode = render.geometry_mode & ~c.word1;
        r.kind  = dlsd_pkg::KIND_GEOMMODE;
        r.word1 = render.geometry_mode;
      end
      dlsd_pkg::OP_OTHERMODE_H: begin
        m = field_mask(c.low);
        render.othermode_high = (render.othermode_high & ~m) | (c.word1 & m);
        r.kind  = dlsd_pkg::KIND_OTHER_H;
        r.word1 = render.othermode_high;
      end
      dlsd_pkg::OP_OTHERMODE_L: begin
        m = field_mask(c.low);
        render.othermode_low = (render.othermode_low & ~m) | (c.word1 & m);
        r.kind  = dlsd_pkg::KIND_OTHER_L;
        r.word1 = render.othermode_low;
      end
      dlsd_pkg::OP_TEXTURE: begin
        render.tex_level = c.low[13:11];
        render.tex_tile  = c.low[10:8];
        render.tex_on    = (c.low[7:0] != 8'h00);
        render.scale_s   = c.word1[31:16];
        render.scale_t   = c.word1[15:0];
        r.kind = dlsd_pkg::KIND_TEXTURE;
      end
      dlsd_pkg::OP_MOVEWORD: begin
        case (c.low[7:0])
          dlsd_pkg::MW_SEGMENT: begin
            // offset is low[23:8]; segment = offset / 4, dropped if >= 16
            if (c.low[23:14] == '0) seg_base[c.low[13:10]] = c.word1;
          end
          dlsd_pkg::MW_LIGHTS: begin
            n = c.word1[11:5];
            if (n != 7'd0) n = n - 7'd1;
            render.lights = n;
          end
          dlsd_pkg::MW_PERSPNRM: begin
            render.persp_norm = c.word1[15:0];
          end
          default: begin
          end
        endcase
        r.kind = dlsd_pkg::KIND_ABSORBED;
      end
      default: begin
        if (c.opcode >= dlsd_pkg::OP_RDP_FIRST) begin
          r.kind  = dlsd_pkg::KIND_RDP;
          r.word1 = (c.opcode >= dlsd_pkg::OP_IMAGE_FIRST) ? seg_addr(c.word1)
                                                           : c.word1;
        end else begin
          r.kind = dlsd_pkg::KIND_UNKNOWN;
        end
      end
    endcase
    r.tex_level   = render.tex_level;
    r.tex_tile    = render.tex_tile;
    r.tex_on      = render.tex_on;
    r.scale_s     = render.scale_s;
    r.scale_t     = render.scale_t;
    r.light_count = render.lights;
    r.persp_value = render.persp_norm;
    return r;
  endfunction

  function automatic void add_cmd(logic [7:0] op, logic [23:0] low, logic [31:0] w1,
                                  logic drain);
    pending_t p;
    p.drain      = drain;
    p.cmd.opcode = op;
    p.cmd.low    = low;
    p.cmd.word1  = w1;
    cmd_q = {cmd_q, p};
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_val,
                                      logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, exp_val,
               act_val);
      mismatches++;
    end
  endfunction

  // Sender: predicts on each accepted word, then draws a gap before the next.
  // Burst stretches run with no gaps at all.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_q = {expected_q, decode_command(cur_cmd)};
      end
      if (!(s_tvalid && !s_tready)) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (cmd_q.size() > 0 && !(cmd_q[0].drain && expected_q.size() > 0)) begin
          next_item = cmd_q.pop_front();
          cur_cmd   = next_item.cmd;
          s_tdata  <= {next_item.cmd.word1, next_item.cmd.low, next_item.cmd.opcode};
          s_tvalid <= 1'b1;
          if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result word against the oldest prediction, then
  // stalls for a random number of cycles.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t ns: unexpected result word, expected none actual %h kind %h",
                   $time, m_tdata, m_tuser);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("kind",        32'(want.kind),        32'(m_tuser));
          check_field("out_word0",   want.word0,            m_tdata[31:0]);
          check_field("out_word1",   want.word1,            m_tdata[63:32]);
          check_field("tex_level",   32'(want.tex_level),   32'(m_tdata[66:64]));
          check_field("tex_tile",    32'(want.tex_tile),    32'(m_tdata[69:67]));
          check_field("tex_on",      32'(want.tex_on),      32'(m_tdata[70]));
          check_field("scale_s",     32'(want.scale_s),     32'(m_tdata[86:71]));
          check_field("scale_t",     32'(want.scale_t),     32'(m_tdata[102:87]));
          check_field("light_count", 32'(want.light_count), 32'(m_tdata[109:103]));
          check_field("persp_value", 32'(want.persp_value), 32'(m_tdata[125:110]));
          check_field("pad",         32'd0,                 32'(m_tdata[127:126]));
          check_field("end_list",    32'(want.end_list),    32'(m_tlast));
        end
        if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
        recv_stall = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: too long with no word moving on either side means a hang.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    dlsd_pkg::cmd_t c;
    int             pick;
    clk         = 1'b0;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    m_tready    = 1'b0;
    mismatches  = 0;
    idle_cycles = 0;
    send_gap    = 0;
    recv_stall  = 0;
    send_burst  = 1'b0;
    recv_burst  = 1'b0;
    render      = dlsd_pkg::STATE_RESET;
    foreach (seg_base[k]) seg_base[k] = '0;

    known_ops = '{dlsd_pkg::OP_NOOP, dlsd_pkg::OP_MTX, dlsd_pkg::OP_MOVEMEM,
                  dlsd_pkg::OP_VTX, dlsd_pkg::OP_DL, dlsd_pkg::OP_TRI2,
                  dlsd_pkg::OP_RDPHALF_CNT, dlsd_pkg::OP_RDPHALF_2,
                  dlsd_pkg::OP_RDPHALF_1, dlsd_pkg::OP_LINE3D, dlsd_pkg::OP_CLRGEOM,
                  dlsd_pkg::OP_SETGEOM, dlsd_pkg::OP_ENDDL, dlsd_pkg::OP_OTHERMODE_L,
                  dlsd_pkg::OP_OTHERMODE_H, dlsd_pkg::OP_TEXTURE,
                  dlsd_pkg::OP_MOVEWORD, dlsd_pkg::OP_POPMTX, dlsd_pkg::OP_CULLDL,
                  dlsd_pkg::OP_TRI1, dlsd_pkg::OP_RDP_NOOP, dlsd_pkg::OP_RDP_FIRST,
                  dlsd_pkg::OP_IMAGE_FIRST, OP_IMAGE_LAST};
    simple_ops = '{dlsd_pkg::OP_ENDDL, dlsd_pkg::OP_TRI1, dlsd_pkg::OP_TRI2,
                   dlsd_pkg::OP_POPMTX, dlsd_pkg::OP_CULLDL, dlsd_pkg::OP_NOOP,
                   dlsd_pkg::OP_MOVEMEM, dlsd_pkg::OP_RDPHALF_CNT,
                   dlsd_pkg::OP_RDPHALF_2, dlsd_pkg::OP_RDPHALF_1,
                   dlsd_pkg::OP_LINE3D, dlsd_pkg::OP_RDP_NOOP,
                   dlsd_pkg::OP_RDP_FIRST, OP_UNDEF_LOW, OP_UNDEF_HIGH};

    // Directed: segment loads incl. out-of-range index, then translation.
    add_cmd(dlsd_pkg::OP_MOVEWORD, {16'h0004, dlsd_pkg::MW_SEGMENT}, 32'h8010_0000,
            1'b0);  // seg 1
    add_cmd(dlsd_pkg::OP_MOVEWORD, {16'h003C, dlsd_pkg::MW_SEGMENT}, 32'hFFFF_FFF0,
            1'b0);  // seg 15
    add_cmd(dlsd_pkg::OP_MOVEWORD, {16'h0040, dlsd_pkg::MW_SEGMENT}, 32'hDEAD_BEEF,
            1'b0);  // seg 16, dropped
    add_cmd(dlsd_pkg::OP_MOVEWORD, {16'hFFFF, dlsd_pkg::MW_SEGMENT}, 32'h1234_5678,
            1'b0);  // dropped
    add_cmd(dlsd_pkg::OP_MTX, 24'h000000, 32'h0100_0010, 1'b0);
    add_cmd(dlsd_pkg::OP_VTX, 24'hFFFFFF, 32'hFFFF_FFFF, 1'b0);  // seg 15, sum wraps
    add_cmd(dlsd_pkg::OP_DL, 24'h000000, 32'hF100_0000, 1'b0);   // top nibble ignored
    add_cmd(dlsd_pkg::OP_DL, 24'h010000, 32'h0000_0004, 1'b0);   // branch ends the list
    add_cmd(dlsd_pkg::OP_SETGEOM, 24'h000000, 32'hFFFF_FFFF, 1'b0);
    add_cmd(dlsd_pkg::OP_CLRGEOM, 24'hFFFFFF, 32'h0000_FFFF, 1'b0);
    // Othermode masks: full width, top bit only, shift past 31, oversized length.
    add_cmd(dlsd_pkg::OP_OTHERMODE_H, 24'h00001F, 32'hA5A5_A5A5, 1'b0);
    add_cmd(dlsd_pkg::OP_OTHERMODE_H, 24'h001F00, 32'h0000_0000, 1'b0);
    add_cmd(dlsd_pkg::OP_OTHERMODE_L, 24'h002003, 32'hFFFF_FFFF, 1'b0);
    add_cmd(dlsd_pkg::OP_OTHERMODE_L, 24'h00C8FF, 32'h0F0F_0F0F, 1'b0);
    add_cmd(dlsd_pkg::OP_OTHERMODE_L, 24'h000407, 32'h0000_0000, 1'b0);
    add_cmd(dlsd_pkg::OP_TEXTURE, 24'hFFFFFF, 32'hFFFF_FFFF, 1'b0);
    add_cmd(dlsd_pkg::OP_TEXTURE, 24'h000000, 32'h0001_8000, 1'b0);
    // Light count: largest value, zero stays zero, one light rounds to zero.
    add_cmd(dlsd_pkg::OP_MOVEWORD, {16'h0000, dlsd_pkg::MW_LIGHTS}, 32'h0000_0FFF, 1'b0);
    add_cmd(dlsd_pkg::OP_MOVEWORD, {16'hFFFF, dlsd_pkg::MW_LIGHTS}, 32'hFFFF_F01F, 1'b0);
    add_cmd(dlsd_pkg::OP_MOVEWORD, {16'h0000, dlsd_pkg::MW_LIGHTS}, 32'h0000_0020, 1'b0);
    add_cmd(dlsd_pkg::OP_MOVEWORD, {16'h0000, dlsd_pkg::MW_PERSPNRM}, 32'hFFFF_0000,
            1'b0);
    add_cmd(dlsd_pkg::OP_MOVEWORD, {16'h0000, MW_UNUSED}, 32'hFFFF_FFFF, 1'b0);
    add_cmd(dlsd_pkg::OP_IMAGE_FIRST, 24'h000000, 32'h0F00_0001, 1'b0);
    add_cmd(OP_IMAGE_LAST, 24'hFFFFFF, 32'h01FF_FFFF, 1'b0);
    foreach (simple_ops[k]) add_cmd(simple_ops[k], 24'($urandom), $urandom, 1'b0);

    // Random: mostly decodable commands with shaped operands, some raw noise.
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      c.low   = 24'($urandom);
      c.word1 = $urandom;
      pick    = $urandom_range(0, 99);
      if (pick < 55) begin
        c.opcode = known_ops[$urandom_range(0, known_ops.size() - 1)];
      end else if (pick < 80) begin
        c.opcode = dlsd_pkg::OP_MOVEWORD;
      end else if (pick < 90) begin
        c.opcode = 8'($urandom_range(dlsd_pkg::OP_RDP_FIRST, OP_IMAGE_LAST));
      end else begin
        c.opcode = 8'($urandom_range(0, 255));
      end
      if (c.opcode == dlsd_pkg::OP_MOVEWORD && $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 2))
          0: begin
            c.low[7:0]   = dlsd_pkg::MW_SEGMENT;
            c.low[23:10] = 14'($urandom_range(0, dlsd_pkg::SEGMENTS + 1));
          end
          1: c.low[7:0] = dlsd_pkg::MW_LIGHTS;
          default: c.low[7:0] = dlsd_pkg::MW_PERSPNRM;
        endcase
      end
      if ((c.opcode == dlsd_pkg::OP_OTHERMODE_H || c.opcode == dlsd_pkg::OP_OTHERMODE_L) &&
          $urandom_range(0, 3) != 0) begin
        c.low[7:0]  = 8'($urandom_range(0, 31));
        c.low[15:8] = 8'($urandom_range(0, 34));
      end
      add_cmd(c.opcode, c.low, c.word1, i == 0 || $urandom_range(0, 149) == 0);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (cmd_q.size() != 0 || s_tvalid || expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
